[sv/mpt_pkg.sv]
package mpt_pkg;

  localparam int unsigned RAW_W   = 25;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned TURN_W  = 16;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned FMT_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_FORMAT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_OFFSET = 1'd1;

  localparam logic [FMT_W-1:0] FMT_25B_SH7     = 2'd0;
  localparam logic [FMT_W-1:0] FMT_23B_INV_SH9 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_13B_SH19    = 2'd2;

  localparam logic [1:0] QUAD_FIRST = 2'b00;
  localparam logic [1:0] QUAD_LAST  = 2'b11;

  localparam logic [TURN_W-1:0] TURN_MIN = 16'h8000;
  localparam logic [TURN_W-1:0] TURN_MAX = 16'h7fff;

  typedef struct packed {
    logic [FMT_W-1:0] data_format;
    logic [POS_W-1:0] position_offset;
  } mpt_cfg_t;

  typedef struct packed {
    logic             new_data;
    logic             mode_error;
    logic [RAW_W-1:0] turn_raw;
  } mpt_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             origin_detected;
    logic [POS_W-1:0] index_position;
    logic             wrap_seen;
    logic             capture_seen;
  } mpt_result_t;

  typedef struct packed {
    logic              ok;
    logic [FRAC_W-1:0] frac_hi;
  } mpt_scaled_t;

  // top 16 bits of the scaled turn fraction
  function automatic mpt_scaled_t scale_reading(logic [FMT_W-1:0] fmt,
                                                logic [RAW_W-1:0] raw);
    mpt_scaled_t s;
    s.ok      = 1'b1;
    s.frac_hi = '0;
    case (fmt)
      FMT_25B_SH7:     s.frac_hi = raw[24:9];
      FMT_23B_INV_SH9: s.frac_hi = ~raw[22:7];
      FMT_13B_SH19:    s.frac_hi = {raw[12:0], 3'b000};
      default:         s.ok      = 1'b0;
    endcase
    return s;
  endfunction

endpackage

[sv/mpt_in_if.sv]
interface mpt_in_if;
  logic                            valid;
  logic                            ready;
  logic                            new_data;
  logic                            mode_error;
  logic [mpt_pkg::RAW_W-1:0]       turn_raw;

  modport source (output valid, new_data, mode_error, turn_raw, input ready);
  modport sink   (input valid, new_data, mode_error, turn_raw, output ready);
endinterface

[sv/mpt_out_if.sv]
interface mpt_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mpt_pkg::POS_W-1:0]  position;
  logic                              origin_detected;
  logic signed [mpt_pkg::POS_W-1:0]  index_position;
  logic                              wrap_seen;
  logic                              capture_seen;

  modport source (output valid, position, origin_detected, index_position, wrap_seen,
                  capture_seen, input ready);
  modport sink   (input valid, position, origin_detected, index_position, wrap_seen,
                  capture_seen, output ready);
endinterface

[sv/mpt_cfg_if.sv]
interface mpt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mpt_pkg::CFG_IDX_W-1:0]     index;
  logic [mpt_pkg::POS_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/mpt_cfg_regs.sv]
module mpt_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  mpt_cfg_if.sink           cfg_bus,
  output mpt_pkg::mpt_cfg_t cfg
);

  logic [mpt_pkg::FMT_W-1:0] data_format_r;
  logic [mpt_pkg::POS_W-1:0] position_offset_r;
  logic                      wr;

  assign cfg_bus.ready = 1'b1;
  assign wr = cfg_bus.valid && cfg_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_format_r     <= mpt_pkg::FMT_23B_INV_SH9;
      position_offset_r <= '0;
    end else if (wr) begin
      case (cfg_bus.index)
        mpt_pkg::CFG_DATA_FORMAT:     data_format_r     <= cfg_bus.data[mpt_pkg::FMT_W-1:0];
        mpt_pkg::CFG_POSITION_OFFSET: position_offset_r <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  assign cfg.data_format     = data_format_r;
  assign cfg.position_offset = position_offset_r;

endmodule

[sv/mpt_tracker.sv]
module mpt_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  mpt_pkg::mpt_item_t   item,
  input  mpt_pkg::mpt_cfg_t    cfg,
  output mpt_pkg::mpt_result_t result
);

  logic [mpt_pkg::FRAC_W-1:0] frac_r, frac_nxt;
  logic [mpt_pkg::TURN_W-1:0] turn_r, turn_nxt;
  logic [mpt_pkg::POS_W-1:0]  index_r, index_nxt;
  logic                       wrap_r, wrap_nxt;
  logic                       capt_r, capt_nxt;

  mpt_pkg::mpt_scaled_t       scaled;
  logic                       ok, down, up, origin;
  logic [mpt_pkg::TURN_W-1:0] boundary;

  always_comb begin
    scaled   = mpt_pkg::scale_reading(cfg.data_format, item.turn_raw);
    ok       = item.new_data && !item.mode_error && scaled.ok;
    down     = ok && (frac_r[15:14] == mpt_pkg::QUAD_FIRST) && scaled.frac_hi[15];
    up       = ok && (frac_r[15:14] == mpt_pkg::QUAD_LAST) && !scaled.frac_hi[15];
    origin   = down || up;
    frac_nxt = ok ? scaled.frac_hi : frac_r;
    turn_nxt = turn_r;
    if (down) begin
      turn_nxt = turn_r - 16'd1;
    end else if (up) begin
      turn_nxt = turn_r + 16'd1;
    end
    boundary  = down ? turn_r : turn_nxt;
    wrap_nxt  = wrap_r || (down && turn_r == mpt_pkg::TURN_MIN)
                       || (up && turn_r == mpt_pkg::TURN_MAX);
    capt_nxt  = capt_r || origin;
    index_nxt = origin ? ({boundary, 16'h0000} + cfg.position_offset) : index_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r  <= '0;
      turn_r  <= '0;
      index_r <= '0;
      wrap_r  <= 1'b0;
      capt_r  <= 1'b0;
    end else if (advance) begin
      frac_r  <= frac_nxt;
      turn_r  <= turn_nxt;
      index_r <= index_nxt;
      wrap_r  <= wrap_nxt;
      capt_r  <= capt_nxt;
    end
  end

  assign result.position        = {turn_nxt, frac_nxt};
  assign result.origin_detected = origin;
  assign result.index_position  = index_nxt;
  assign result.wrap_seen       = wrap_nxt;
  assign result.capture_seen    = capt_nxt;

endmodule

[sv/multiturn_position_tracker_core.sv]
// Multiturn position tracker. Each input beat is one encoder poll; each poll yields
// exactly one result beat with the packed position (turn count in bits 31..16,
// top 16 fraction bits in 15..0), the boundary-crossing strobe, the last captured
// index position and the sticky wrap and capture flags. The block has an input
// register and a result register with the tracking logic between them, so it takes
// one beat per cycle while the output is ready. An accepted poll waits in the input
// register and its result beat is then written into the result register. With the
// result held, one more poll waits in the input register before the input stalls.
// Configuration (data format, index offset) is written through the cfg channel,
// which is always ready, and should only change while no polls are in flight.
module multiturn_position_tracker_core (
  input  logic      clk,
  input  logic      rst_n,
  mpt_in_if.sink    in_bus,
  mpt_out_if.source out_bus,
  mpt_cfg_if.sink   cfg_bus
);

  mpt_pkg::mpt_cfg_t    cfg;
  mpt_pkg::mpt_item_t   item_r;
  mpt_pkg::mpt_result_t result;
  mpt_pkg::mpt_result_t res_r;
  logic                 in_valid_r;
  logic                 out_valid_r;
  logic                 in_acc;
  logic                 advance;

  mpt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  mpt_tracker u_trk (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (result)
  );

  assign advance      = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || advance;
  assign in_acc       = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.new_data   <= in_bus.new_data;
      item_r.mode_error <= in_bus.mode_error;
      item_r.turn_raw   <= in_bus.turn_raw;
    end
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.position        = res_r.position;
  assign out_bus.origin_detected = res_r.origin_detected;
  assign out_bus.index_position  = res_r.index_position;
  assign out_bus.wrap_seen       = res_r.wrap_seen;
  assign out_bus.capture_seen    = res_r.capture_seen;

endmodule
